// ===== design/tmprof_pkg.sv =====
// Package of the trapezoid motion profile: types, codes, widths and
// saturation helpers. Used by every module of the block; depends on nothing.
package tmprof_pkg;

  localparam int VW = 32;             // value width
  localparam int DW = 2 * VW;         // product / dividend width
  localparam int FB = 16;             // fraction bits
  localparam int LW = VW - 1;         // limit register width
  localparam int AW = DW + 2;         // signed distance accumulator width
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW = $clog2(QUEUE_DEPTH);

  localparam logic CMD_PLAN   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    OP_PLAN,
    OP_SAMPLE,
    OP_ERROR
  } op_e;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_GOAL  = 2'd1,
    REG_VLIM  = 2'd2,
    REG_ALIM  = 2'd3
  } reg_e;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_P_DIST,
    BK_P_VV,
    BK_P_CMP,
    BK_T_DIV,
    BK_T_SQRT,
    BK_T_M1,
    BK_T_M2,
    BK_T_M3,
    BK_T_M4,
    BK_Z_DIV1,
    BK_Z_DIV2,
    BK_Z_DIV3,
    BK_Z_TOT,
    BK_S_CLAMP,
    BK_A_M1,
    BK_A_M2,
    BK_A_M3,
    BK_A_M4,
    BK_C_M1,
    BK_C_M2,
    BK_D_M1,
    BK_D_M2,
    BK_D_M3,
    BK_D_M4,
    BK_D_M5,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    op_e           op;
    logic [VW-1:0] stime;
  } entry_t;

  typedef struct packed {
    logic [VW-1:0] start;
    logic [VW-1:0] goal;
    logic [LW-1:0] vlim;
    logic [LW-1:0] alim;
  } cfg_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic          done;
    logic [VW-1:0] root;
  } sqrt_rsp_t;

  // zero limit counts as one
  function automatic logic [VW-1:0] lim_val(input logic [LW-1:0] r);
    return (r == '0) ? VW'(1) : {1'b0, r};
  endfunction

  function automatic logic [VW-1:0] sat_u(input logic [DW-1:0] x);
    return (x[DW-1:VW] != '0) ? '1 : x[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_s(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] smax;
    logic signed [AW-1:0] smin;
    smax = $signed({{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}});
    smin = $signed({{(AW-VW+1){1'b1}}, {(VW-1){1'b0}}});
    if (x > smax) return {1'b0, {(VW-1){1'b1}}};
    if (x < smin) return {1'b1, {(VW-1){1'b0}}};
    return x[VW-1:0];
  endfunction

endpackage

// ===== design/tmprof_front.sv =====
// Front end of the motion profile: accepts commands and classifies them.
// Depends on tmprof_pkg.
module tmprof_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [31:0]        sample_time_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tmprof_pkg::entry_t q_entry_o
);
  import tmprof_pkg::*;

  logic seen_q;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  // a sample before any accepted plan is an error
  always_comb begin
    q_entry_o.stime = sample_time_i;
    if (command_i == CMD_PLAN) begin
      q_entry_o.op = OP_PLAN;
    end else if (seen_q) begin
      q_entry_o.op = OP_SAMPLE;
    end else begin
      q_entry_o.op = OP_ERROR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (q_push_o && command_i == CMD_PLAN) begin
      seen_q <= 1'b1;
    end
  end

endmodule

// ===== design/tmprof_queue.sv =====
// Short queue between front and back end of the motion profile.
// Depends on tmprof_pkg.
module tmprof_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tmprof_pkg::entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tmprof_pkg::entry_t entry_o
);
  import tmprof_pkg::*;

  entry_t             mem_q [QUEUE_DEPTH];
  logic [QPW-1:0]     wptr_q;
  logic [QPW-1:0]     rptr_q;
  logic [QPW:0]       count_q;

  assign full_o  = (count_q == (QPW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + (QPW+1)'(push_i) - (QPW+1)'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("queue underflow");

endmodule

// ===== design/tmprof_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tmprof_pkg.
module tmprof_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmprof_pkg::div_req_t req_i,
  output tmprof_pkg::div_rsp_t rsp_o
);
  import tmprof_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   rem_sh;
  logic          ge;
  logic [VW:0]   rem_sub;

  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

endmodule

// ===== design/tmprof_sqrt.sv =====
// Bit-pair integer square root, one result bit per cycle.
// Depends on tmprof_pkg.
module tmprof_sqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tmprof_pkg::sqrt_req_t req_i,
  output tmprof_pkg::sqrt_rsp_t rsp_o
);
  import tmprof_pkg::*;

  logic          busy_q;
  logic          done_q;
  logic [DW-1:0] x_q;
  logic [DW-1:0] res_q;
  logic [DW-1:0] bit_q;
  logic [DW-1:0] sum;
  logic          ge;

  assign sum = res_q + bit_q;
  assign ge  = (x_q >= sum);

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[VW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.radicand;
      res_q <= '0;
      bit_q <= DW'(1) << (DW - 2);
    end else if (busy_q) begin
      if (ge) begin
        x_q   <= x_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// ===== design/tmprof_back.sv =====
// Back end of the motion profile: plan sequencer, sampler, shared
// multiplier and output register. Depends on tmprof_pkg.
module tmprof_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tmprof_pkg::cfg_t      cfg_i,
  input  logic                  q_valid_i,
  input  tmprof_pkg::entry_t    q_entry_i,
  output logic                  q_pop_o,
  output tmprof_pkg::div_req_t  div_req_o,
  input  tmprof_pkg::div_rsp_t  div_rsp_i,
  output tmprof_pkg::sqrt_req_t sqrt_req_o,
  input  tmprof_pkg::sqrt_rsp_t sqrt_rsp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  status_o,
  output logic [1:0]            phase_o,
  output logic [31:0]           time_used_o,
  output logic [31:0]           position_o,
  output logic [31:0]           velocity_o,
  output logic [31:0]           acceleration_o,
  output logic [31:0]           duration_o
);
  import tmprof_pkg::*;

  bk_state_e state_q, state_d;

  // plan state
  logic          neg_q;
  logic [VW-1:0] ramp_q, coast_q, peak_q, rdist_q, total_q;

  // work registers
  logic [VW-1:0]        dist_q, t_q, u_q, atd_q;
  logic [DW-1:0]        vv_q, product_q;
  logic signed [AW-1:0] accum_q;
  logic                 res_err_q;
  phase_e               res_phase_q;
  logic signed [VW+1:0] res_vel_q;
  logic [VW-1:0]        res_acc_q;

  logic          out_valid_q, out_status_q;
  logic [1:0]    out_phase_q;
  logic [VW-1:0] out_time_q, out_pos_q, out_vel_q, out_acc_q, out_dur_q;

  logic [VW-1:0] a_lim, v_lim, mul_a, mul_b, tc;
  logic [VW:0]   rc, dg, td;
  logic          dneg, out_free;
  logic [VW-1:0] dmag;
  logic signed [AW-1:0] pos_sum, p16, p17;

  assign a_lim    = lim_val(cfg_i.alim);
  assign v_lim    = lim_val(cfg_i.vlim);
  assign out_free = !out_valid_q || out_ready_i;

  assign dneg = $signed(cfg_i.goal) < $signed(cfg_i.start);
  assign dg   = {cfg_i.goal[VW-1], cfg_i.goal} - {cfg_i.start[VW-1], cfg_i.start};
  assign dmag = dneg ? VW'(-dg) : dg[VW-1:0];

  assign tc = (t_q > total_q) ? total_q : t_q;
  assign rc = {1'b0, ramp_q} + {1'b0, coast_q};
  assign td = {1'b0, tc} - rc;

  assign p16 = $signed({2'b00, product_q >> FB});
  assign p17 = $signed({2'b00, product_q >> (FB + 1)});
  assign pos_sum = $signed({{(AW-VW){cfg_i.start[VW-1]}}, cfg_i.start})
                 + (neg_q ? -accum_q : accum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    div_req_o  = '0;
    sqrt_req_o = '0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_entry_i.op)
            OP_PLAN:   state_d = BK_P_DIST;
            OP_SAMPLE: state_d = BK_S_CLAMP;
            default:   state_d = BK_DONE;
          endcase
        end
      end
      BK_P_DIST: begin
        mul_a   = v_lim;
        mul_b   = v_lim;
        state_d = BK_P_VV;
      end
      BK_P_VV: begin
        mul_a   = dist_q;
        mul_b   = a_lim;
        state_d = BK_P_CMP;
      end
      BK_P_CMP: begin
        div_req_o.start = 1'b1;
        if (vv_q > product_q) begin
          div_req_o.dividend = {dist_q, {VW{1'b0}}};
          div_req_o.divisor  = a_lim;
          state_d            = BK_T_DIV;
        end else begin
          div_req_o.dividend = vv_q;
          div_req_o.divisor  = {a_lim[VW-2:0], 1'b0};
          state_d            = BK_Z_DIV1;
        end
      end
      BK_T_DIV: begin
        if (div_rsp_i.done) begin
          sqrt_req_o.start    = 1'b1;
          sqrt_req_o.radicand = div_rsp_i.quotient;
          state_d             = BK_T_SQRT;
        end
      end
      BK_T_SQRT: begin
        if (sqrt_rsp_i.done) state_d = BK_T_M1;
      end
      BK_T_M1: begin
        mul_a   = a_lim;
        mul_b   = ramp_q;
        state_d = BK_T_M2;
      end
      BK_T_M2: state_d = BK_T_M3;
      BK_T_M3: begin
        mul_a   = peak_q;
        mul_b   = ramp_q;
        state_d = BK_T_M4;
      end
      BK_T_M4: state_d = BK_S_CLAMP;
      BK_Z_DIV1: begin
        if (div_rsp_i.done) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {{(VW-FB){1'b0}}, v_lim, {FB{1'b0}}};
          div_req_o.divisor  = a_lim;
          state_d            = BK_Z_DIV2;
        end
      end
      BK_Z_DIV2: begin
        if (div_rsp_i.done) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {{(VW-FB){1'b0}},
                                dist_q - {rdist_q[VW-2:0], 1'b0}, {FB{1'b0}}};
          div_req_o.divisor  = v_lim;
          state_d            = BK_Z_DIV3;
        end
      end
      BK_Z_DIV3: begin
        if (div_rsp_i.done) state_d = BK_Z_TOT;
      end
      BK_Z_TOT: state_d = BK_S_CLAMP;
      BK_S_CLAMP: begin
        if (tc < ramp_q) begin
          state_d = BK_A_M1;
        end else if ({1'b0, tc} < rc) begin
          state_d = BK_C_M1;
        end else begin
          state_d = BK_D_M1;
        end
      end
      BK_A_M1: begin
        mul_a   = a_lim;
        mul_b   = u_q;
        state_d = BK_A_M2;
      end
      BK_A_M2: state_d = BK_A_M3;
      BK_A_M3: begin
        mul_a   = atd_q;
        mul_b   = u_q;
        state_d = BK_A_M4;
      end
      BK_A_M4: state_d = BK_DONE;
      BK_C_M1: begin
        mul_a   = peak_q;
        mul_b   = u_q;
        state_d = BK_C_M2;
      end
      BK_C_M2: state_d = BK_DONE;
      BK_D_M1: begin
        mul_a   = a_lim;
        mul_b   = u_q;
        state_d = BK_D_M2;
      end
      BK_D_M2: begin
        mul_a   = peak_q;
        mul_b   = u_q;
        state_d = BK_D_M3;
      end
      BK_D_M3: begin
        mul_a   = atd_q;
        mul_b   = u_q;
        state_d = BK_D_M4;
      end
      BK_D_M4: begin
        mul_a   = coast_q;
        mul_b   = peak_q;
        state_d = BK_D_M5;
      end
      BK_D_M5: state_d = BK_DONE;
      BK_DONE: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // plan state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      ramp_q      <= '0;
      coast_q     <= '0;
      peak_q      <= '0;
      rdist_q     <= '0;
      total_q     <= '0;
    end else begin
      if (state_q == BK_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BK_P_DIST: neg_q <= dneg;
        BK_T_SQRT: if (sqrt_rsp_i.done) ramp_q <= sqrt_rsp_i.root;
        BK_T_M2:   peak_q <= sat_u(product_q >> FB);
        BK_T_M4: begin
          rdist_q <= sat_u(product_q >> (FB + 1));
          coast_q <= '0;
          total_q <= sat_u(DW'(ramp_q) << 1);
        end
        BK_Z_DIV1: begin
          if (div_rsp_i.done) begin
            rdist_q <= div_rsp_i.quotient[VW-1:0];
            peak_q  <= v_lim;
          end
        end
        BK_Z_DIV2: if (div_rsp_i.done) ramp_q <= sat_u(div_rsp_i.quotient);
        BK_Z_DIV3: if (div_rsp_i.done) coast_q <= sat_u(div_rsp_i.quotient);
        BK_Z_TOT:  total_q <= sat_u((DW'(ramp_q) << 1) + DW'(coast_q));
        default: ;
      endcase
    end
  end

  // work registers and result payload
  always_ff @(posedge clk_i) begin
    product_q <= DW'(mul_a) * DW'(mul_b);
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          t_q       <= q_entry_i.stime;
          res_err_q <= (q_entry_i.op == OP_ERROR);
        end
      end
      BK_P_DIST: begin
        dist_q <= dmag;
        t_q    <= '0;
      end
      BK_P_VV: vv_q <= product_q;
      BK_S_CLAMP: begin
        t_q <= tc;
        if (tc < ramp_q) begin
          res_phase_q <= PH_ACCEL;
          u_q         <= tc;
        end else if ({1'b0, tc} < rc) begin
          res_phase_q <= PH_CRUISE;
          u_q         <= tc - ramp_q;
        end else begin
          res_phase_q <= PH_DECEL;
          u_q         <= td[VW-1:0];
        end
      end
      BK_A_M2: atd_q <= sat_u(product_q >> FB);
      BK_A_M4: begin
        accum_q   <= p17;
        res_vel_q <= neg_q ? -$signed({2'b00, atd_q}) : $signed({2'b00, atd_q});
        res_acc_q <= neg_q ? -a_lim : a_lim;
      end
      BK_C_M2: begin
        accum_q   <= $signed({{(AW-VW){1'b0}}, rdist_q}) + p16;
        res_vel_q <= neg_q ? -$signed({2'b00, peak_q}) : $signed({2'b00, peak_q});
        res_acc_q <= '0;
      end
      BK_D_M2: atd_q <= sat_u(product_q >> FB);
      BK_D_M3: accum_q <= $signed({{(AW-VW){1'b0}}, rdist_q}) + p16;
      BK_D_M4: accum_q <= accum_q - p17;
      BK_D_M5: begin
        accum_q   <= accum_q + p16;
        res_vel_q <= neg_q ? ($signed({2'b00, atd_q}) - $signed({2'b00, peak_q}))
                           : ($signed({2'b00, peak_q}) - $signed({2'b00, atd_q}));
        res_acc_q <= neg_q ? a_lim : -a_lim;
      end
      BK_DONE: begin
        if (out_free) begin
          if (res_err_q) begin
            out_status_q <= 1'b1;
            out_phase_q  <= PH_ACCEL;
            out_time_q   <= '0;
            out_pos_q    <= '0;
            out_vel_q    <= '0;
            out_acc_q    <= '0;
            out_dur_q    <= '0;
          end else begin
            out_status_q <= 1'b0;
            out_phase_q  <= res_phase_q;
            out_time_q   <= t_q;
            out_pos_q    <= sat_s(pos_sum);
            out_vel_q    <= sat_s({{(AW-VW-2){res_vel_q[VW+1]}}, res_vel_q});
            out_acc_q    <= res_acc_q;
            out_dur_q    <= total_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign phase_o        = out_phase_q;
  assign time_used_o    = out_time_q;
  assign position_o     = out_pos_q;
  assign velocity_o     = out_vel_q;
  assign acceleration_o = out_acc_q;
  assign duration_o     = out_dur_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> duration_o == '0 && position_o == '0 && velocity_o == '0)
    else $error("error result carries data");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> time_used_o <= duration_o)
    else $error("sample time beyond profile duration");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o && phase_o == PH_ACCEL |-> time_used_o < duration_o)
    else $error("accel phase at end of profile");

endmodule

// ===== design/trapezoid_motion_profile.sv =====
// Top level of the trapezoidal motion profile: configuration registers and
// the front end, queue, divider, square root and back end. Uses tmprof_pkg.
//
// Usage:
//   Write start_position, goal_position, velocity_limit and accel_limit
//   through the config port (cfg_we_i, cfg_addr_i, cfg_wdata_i) while the
//   block is idle. Each request on the input channel (valid/ready) gives
//   exactly one result on the output channel (valid/ready).
//   A plan request (command 0) builds the profile and answers with its
//   sample at time zero; a sample request (command 1) returns position,
//   velocity and acceleration at the clamped time. A sample before any plan
//   returns status 1 with all other fields zero.
// Processing:
//   Requests are handled one at a time by the back end. A sample is set by
//   one to four passes through the shared 32x32 multiplier; a plan uses one
//   64-step division and one 32-step square root for a triangle profile and
//   three 64-step divisions for a trapezoid.
// Reset and stalls:
//   Reset clears the plan (no plan present) and loads the register
//   defaults. A two-entry queue keeps taking requests while the back end
//   works; a result held by a stalled receiver holds the back end in its
//   last step, so the queue fills and in_ready_o drops until it is taken.
module trapezoid_motion_profile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [1:0]  phase_o,
  output logic [31:0] time_used_o,
  output logic [31:0] position_o,
  output logic [31:0] velocity_o,
  output logic [31:0] acceleration_o,
  output logic [31:0] duration_o
);
  import tmprof_pkg::*;

  cfg_t      cfg_q;
  logic      q_full, q_push, q_valid, q_pop;
  entry_t    push_entry, head_entry;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // configuration registers, write-only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start <= '0;
      cfg_q.goal  <= '0;
      cfg_q.vlim  <= LW'(65536);
      cfg_q.alim  <= LW'(65536);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_START: cfg_q.start <= cfg_wdata_i;
        REG_GOAL:  cfg_q.goal  <= cfg_wdata_i;
        REG_VLIM:  cfg_q.vlim  <= cfg_wdata_i[LW-1:0];
        REG_ALIM:  cfg_q.alim  <= cfg_wdata_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // accept and classify requests
  tmprof_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .sample_time_i (sample_time_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  // hold classified requests for the back end
  tmprof_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  tmprof_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tmprof_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // plan, sample and drive the result register
  tmprof_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_entry_i      (head_entry),
    .q_pop_o        (q_pop),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .sqrt_req_o     (sqrt_req),
    .sqrt_rsp_i     (sqrt_rsp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .phase_o        (phase_o),
    .time_used_o    (time_used_o),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .duration_o     (duration_o)
  );

endmodule
